FILE: rtl/frame_slot_manager_defines.svh
// ----------------------------------------------------------------------------
// frame_slot_manager_defines
// Assertion macros used by the checker of the frame slot manager.
// ----------------------------------------------------------------------------
// Each macro expects a signal named clk in the scope where it is used; FSLOT_ASSERT also needs arst_n.
`ifndef FRAME_SLOT_MANAGER_DEFINES_SVH
`define FRAME_SLOT_MANAGER_DEFINES_SVH

// Checked only outside reset.
`define FSLOT_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define FSLOT_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/fslot_pkg.sv
// ----------------------------------------------------------------------------
// fslot_pkg
// Shared types and constants of the frame slot manager.
// ----------------------------------------------------------------------------
`default_nettype none

package fslot_pkg;

	localparam int SLOT_COUNT_DEF = 3;
	localparam int FIFO_DEPTH_DEF = 8;

	localparam int FUNC_W    = 4;
	localparam int SLOT_IN_W = 8;
	localparam int SLOT_W    = 3;
	localparam int MARK_W    = 3;

	// Bit positions inside the per-slot mark word.
	localparam int MARK_P = 0;
	localparam int MARK_U = 1;
	localparam int MARK_R = 2;

	typedef enum logic [FUNC_W-1:0] {
		FN_FREE           = 4'd0,
		FN_PREPARED       = 4'd1,
		FN_UPLOADED       = 4'd2,
		FN_RENDERING      = 4'd3,
		FN_RENDERED       = 4'd4,
		FN_GET_FREE       = 4'd5,
		FN_GET_PREPARED   = 4'd6,
		FN_GET_RENDERABLE = 4'd7,
		FN_SET_LAST       = 4'd8
	} fslot_func_t;

	// Source of the single mark-table read address.
	typedef enum logic [2:0] {
		ADDR_SLOT,
		ADDR_PHEAD,
		ADDR_UHEAD,
		ADDR_LAST,
		ADDR_SCAN
	} fslot_addr_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_EXEC,
		ST_FREE,
		ST_PREP,
		ST_REND,
		ST_LAST,
		ST_REPORT
	} fslot_state_t;

	typedef struct packed {
		logic        capture;
		fslot_addr_t addr_sel;
		logic        apply_event;
		logic        cnt_init;
		logic        cnt_step;
		logic        p_pop;
		logic        u_pop;
		logic        grant;
		logic        move_search;
		logic        load_out;
	} fslot_cmd_t;

	typedef struct packed {
		fslot_func_t func;
		logic        p_empty;
		logic        u_empty;
		logic        addr_ok;
		logic        mark_p;
		logic        mark_u;
		logic        mark_r;
		logic        addr_is_last;
		logic        last_valid;
		logic        cnt_last;
		logic        out_free;
	} fslot_sts_t;

endpackage

`default_nettype wire

FILE: rtl/fslot_ctrl.sv
// ----------------------------------------------------------------------------
// fslot_ctrl
// Sequencer that walks one request through the slot datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module fslot_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  fslot_pkg::fslot_sts_t  sts,
	output fslot_pkg::fslot_cmd_t  cmd
);

	fslot_pkg::fslot_state_t state_q;
	fslot_pkg::fslot_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fslot_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_stall = (state_q != fslot_pkg::ST_IDLE);

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			fslot_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_d = fslot_pkg::ST_DISPATCH;
				end
			end
			fslot_pkg::ST_DISPATCH: begin
				unique case (sts.func) inside
					fslot_pkg::FN_FREE, fslot_pkg::FN_PREPARED, fslot_pkg::FN_UPLOADED,
					fslot_pkg::FN_RENDERING, fslot_pkg::FN_RENDERED,
					fslot_pkg::FN_SET_LAST: begin
						state_d = fslot_pkg::ST_EXEC;
					end
					fslot_pkg::FN_GET_FREE:       state_d = fslot_pkg::ST_FREE;
					fslot_pkg::FN_GET_PREPARED:   state_d = fslot_pkg::ST_PREP;
					fslot_pkg::FN_GET_RENDERABLE: state_d = fslot_pkg::ST_REND;
					default:                      state_d = fslot_pkg::ST_REPORT;
				endcase
			end
			fslot_pkg::ST_EXEC: begin
				state_d = fslot_pkg::ST_REPORT;
			end
			fslot_pkg::ST_FREE: begin
				if ((sts.addr_ok && !sts.mark_p) || sts.cnt_last) begin
					state_d = fslot_pkg::ST_REPORT;
				end
			end
			fslot_pkg::ST_PREP: begin
				if (sts.p_empty) begin
					state_d = fslot_pkg::ST_REPORT;
				end else if (sts.addr_ok && sts.mark_p) begin
					state_d = fslot_pkg::ST_REPORT;
				end
			end
			fslot_pkg::ST_REND: begin
				if (sts.u_empty) begin
					state_d = fslot_pkg::ST_LAST;
				end else if (sts.addr_ok && sts.mark_u && !sts.mark_r) begin
					state_d = fslot_pkg::ST_REPORT;
				end else if (sts.cnt_last) begin
					state_d = fslot_pkg::ST_LAST;
				end
			end
			fslot_pkg::ST_LAST: begin
				state_d = fslot_pkg::ST_REPORT;
			end
			fslot_pkg::ST_REPORT: begin
				if (sts.out_free) begin
					state_d = fslot_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = fslot_pkg::ST_IDLE;
			end
		endcase
	end

	// Commands.
	always_comb begin
		cmd = '0;
		unique case (state_q)
			fslot_pkg::ST_IDLE: begin
				cmd.capture = in_valid;
			end
			fslot_pkg::ST_DISPATCH: begin
				cmd.cnt_init = 1'b1;
			end
			fslot_pkg::ST_EXEC: begin
				cmd.addr_sel    = fslot_pkg::ADDR_SLOT;
				cmd.apply_event = 1'b1;
			end
			fslot_pkg::ST_FREE: begin
				cmd.addr_sel = fslot_pkg::ADDR_SCAN;
				if (sts.addr_ok && !sts.mark_p) begin
					cmd.grant       = 1'b1;
					cmd.move_search = 1'b1;
				end else if (!sts.cnt_last) begin
					cmd.cnt_step = 1'b1;
				end
			end
			fslot_pkg::ST_PREP: begin
				cmd.addr_sel = fslot_pkg::ADDR_PHEAD;
				if (!sts.p_empty) begin
					if (!sts.addr_ok || !sts.mark_p) begin
						cmd.p_pop = 1'b1;
					end else if (!sts.mark_u && !sts.mark_r && !sts.addr_is_last) begin
						cmd.p_pop = 1'b1;
						cmd.grant = 1'b1;
					end
				end
			end
			fslot_pkg::ST_REND: begin
				cmd.addr_sel = fslot_pkg::ADDR_UHEAD;
				if (!sts.u_empty) begin
					cmd.u_pop = 1'b1;
					if (sts.addr_ok && sts.mark_u && !sts.mark_r) begin
						cmd.grant = 1'b1;
					end else begin
						cmd.cnt_step = 1'b1;
					end
				end
			end
			fslot_pkg::ST_LAST: begin
				cmd.addr_sel = fslot_pkg::ADDR_LAST;
				cmd.grant    = sts.last_valid && sts.addr_ok && !sts.mark_r;
			end
			fslot_pkg::ST_REPORT: begin
				cmd.addr_sel = fslot_pkg::ADDR_SLOT;
				cmd.load_out = sts.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

`default_nettype wire

FILE: rtl/fslot_dp.sv
// ----------------------------------------------------------------------------
// fslot_dp
// Slot marks, the prepared and uploaded queues, pointers and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module fslot_dp #(
	parameter int SLOT_COUNT = fslot_pkg::SLOT_COUNT_DEF,
	parameter int FIFO_DEPTH = fslot_pkg::FIFO_DEPTH_DEF
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic [fslot_pkg::FUNC_W-1:0]       func,
	input  wire logic [fslot_pkg::SLOT_IN_W-1:0]    slot,
	input  fslot_pkg::fslot_cmd_t                   cmd,
	output fslot_pkg::fslot_sts_t                   sts,
	output logic                                    out_valid,
	input  wire logic                               out_stall,
	output logic [fslot_pkg::SLOT_W-1:0]            slot_out,
	output logic                                    slot_found,
	output logic                                    queue_full,
	output logic                                    input_slot_rendering,
	output logic [fslot_pkg::SLOT_W-1:0]            last_shown,
	output logic                                    last_shown_known
);

	localparam int SIW = $clog2(SLOT_COUNT);
	localparam int PW  = $clog2(FIFO_DEPTH);

	function automatic logic [PW-1:0] adv(input logic [PW-1:0] p);
		return (p == PW'(FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	fslot_pkg::fslot_func_t               func_q;
	logic [fslot_pkg::SLOT_IN_W-1:0]      slot_q;
	logic [fslot_pkg::MARK_W-1:0]         marks_q [SLOT_COUNT];
	logic [fslot_pkg::SLOT_W-1:0]         pfifo_q [FIFO_DEPTH];
	logic [fslot_pkg::SLOT_W-1:0]         ufifo_q [FIFO_DEPTH];
	logic [PW-1:0]                        pwr_q, prd_q, uwr_q, urd_q;
	logic [fslot_pkg::SLOT_W-1:0]         last_q;
	logic                                 last_valid_q;
	logic [SIW-1:0]                       search_q, idx_q, cnt_q;
	logic                                 found_q, full_q;
	logic [fslot_pkg::SLOT_W-1:0]         granted_q;
	logic                                 out_valid_q;
	logic [fslot_pkg::SLOT_W-1:0]         slot_out_q, last_shown_q;
	logic                                 slot_found_q, queue_full_q, rendering_q;
	logic                                 last_known_q;

	logic [fslot_pkg::SLOT_IN_W-1:0]      addr;
	logic                                 addr_ok;
	logic                                 slot_ok;
	logic [fslot_pkg::MARK_W-1:0]         rd_marks;
	logic [fslot_pkg::MARK_W-1:0]         ev_marks;
	logic                                 ev_write, p_push, u_push, p_drop, u_drop, set_last;
	logic                                 out_free;

	assign slot_ok = slot_q < fslot_pkg::SLOT_IN_W'(SLOT_COUNT);

	// One read port on the mark table; the sequencer picks its address.
	always_comb begin
		unique case (cmd.addr_sel)
			fslot_pkg::ADDR_SLOT:  addr = slot_q;
			fslot_pkg::ADDR_PHEAD: addr = fslot_pkg::SLOT_IN_W'(pfifo_q[prd_q]);
			fslot_pkg::ADDR_UHEAD: addr = fslot_pkg::SLOT_IN_W'(ufifo_q[urd_q]);
			fslot_pkg::ADDR_LAST:  addr = fslot_pkg::SLOT_IN_W'(last_q);
			fslot_pkg::ADDR_SCAN:  addr = fslot_pkg::SLOT_IN_W'(idx_q);
			default:               addr = slot_q;
		endcase
	end

	assign addr_ok  = addr < fslot_pkg::SLOT_IN_W'(SLOT_COUNT);
	assign rd_marks = addr_ok ? marks_q[addr[SIW-1:0]] : '0;

	// Event decode on the old marks of the named slot.
	always_comb begin
		ev_marks = rd_marks;
		ev_write = 1'b0;
		p_push   = 1'b0;
		u_push   = 1'b0;
		set_last = 1'b0;
		if (cmd.apply_event && slot_ok) begin
			unique case (func_q)
				fslot_pkg::FN_FREE: begin
					ev_marks = '0;
					ev_write = 1'b1;
				end
				fslot_pkg::FN_PREPARED: begin
					ev_marks[fslot_pkg::MARK_P] = 1'b1;
					ev_write = 1'b1;
					p_push   = !rd_marks[fslot_pkg::MARK_P];
				end
				fslot_pkg::FN_UPLOADED: begin
					ev_marks[fslot_pkg::MARK_P] = 1'b0;
					ev_marks[fslot_pkg::MARK_U] = 1'b1;
					ev_write = 1'b1;
					u_push   = !rd_marks[fslot_pkg::MARK_U] && !rd_marks[fslot_pkg::MARK_R];
				end
				fslot_pkg::FN_RENDERING: begin
					ev_marks[fslot_pkg::MARK_R] = 1'b1;
					ev_write = 1'b1;
					set_last = 1'b1;
				end
				fslot_pkg::FN_RENDERED: begin
					ev_marks[fslot_pkg::MARK_R] = 1'b0;
					ev_marks[fslot_pkg::MARK_U] = 1'b0;
					ev_write = 1'b1;
				end
				fslot_pkg::FN_SET_LAST: begin
					set_last = 1'b1;
				end
				default: begin
					ev_write = 1'b0;
				end
			endcase
		end
	end

	// A queue keeps one entry free so that full and empty differ.
	assign p_drop = p_push && (adv(pwr_q) == prd_q);
	assign u_drop = u_push && (adv(uwr_q) == urd_q);

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			func_q <= fslot_pkg::fslot_func_t'(func);
			slot_q <= slot;
		end
		if (p_push && !p_drop) begin
			pfifo_q[pwr_q] <= slot_q[fslot_pkg::SLOT_W-1:0];
		end
		if (u_push && !u_drop) begin
			ufifo_q[uwr_q] <= slot_q[fslot_pkg::SLOT_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOT_COUNT; i++) begin
				marks_q[i] <= '0;
			end
		end else if (ev_write) begin
			marks_q[slot_q[SIW-1:0]] <= ev_marks;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pwr_q        <= '0;
			prd_q        <= '0;
			uwr_q        <= '0;
			urd_q        <= '0;
			last_q       <= '0;
			last_valid_q <= 1'b0;
			search_q     <= '0;
			idx_q        <= '0;
			cnt_q        <= '0;
			found_q      <= 1'b0;
			full_q       <= 1'b0;
			granted_q    <= '0;
		end else begin
			if (p_push && !p_drop) begin
				pwr_q <= adv(pwr_q);
			end
			if (u_push && !u_drop) begin
				uwr_q <= adv(uwr_q);
			end
			if (cmd.p_pop) begin
				prd_q <= adv(prd_q);
			end
			if (cmd.u_pop) begin
				urd_q <= adv(urd_q);
			end
			if (set_last) begin
				last_q       <= slot_q[fslot_pkg::SLOT_W-1:0];
				last_valid_q <= 1'b1;
			end
			if (cmd.cnt_init) begin
				cnt_q <= '0;
				idx_q <= search_q;
			end else if (cmd.cnt_step) begin
				cnt_q <= cnt_q + 1'b1;
				idx_q <= (idx_q == SIW'(SLOT_COUNT - 1)) ? '0 : idx_q + 1'b1;
			end
			if (cmd.move_search) begin
				search_q <= (idx_q == SIW'(SLOT_COUNT - 1)) ? '0 : idx_q + 1'b1;
			end
			if (cmd.capture) begin
				found_q   <= 1'b0;
				full_q    <= 1'b0;
				granted_q <= '0;
			end else begin
				if (p_drop || u_drop) begin
					full_q <= 1'b1;
				end
				if (cmd.grant) begin
					found_q   <= 1'b1;
					granted_q <= addr[fslot_pkg::SLOT_W-1:0];
				end
			end
		end
	end

	// Result register; the sequencer may finish the next item behind it.
	assign out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			slot_out_q   <= granted_q;
			slot_found_q <= found_q;
			queue_full_q <= full_q;
			rendering_q  <= slot_ok && rd_marks[fslot_pkg::MARK_R];
			last_shown_q <= last_q;
			last_known_q <= last_valid_q;
		end
	end

	assign out_valid            = out_valid_q;
	assign slot_out             = slot_out_q;
	assign slot_found           = slot_found_q;
	assign queue_full           = queue_full_q;
	assign input_slot_rendering = rendering_q;
	assign last_shown           = last_shown_q;
	assign last_shown_known     = last_known_q;

	always_comb begin
		sts              = '0;
		sts.func         = func_q;
		sts.p_empty      = (pwr_q == prd_q);
		sts.u_empty      = (uwr_q == urd_q);
		sts.addr_ok      = addr_ok;
		sts.mark_p       = rd_marks[fslot_pkg::MARK_P];
		sts.mark_u       = rd_marks[fslot_pkg::MARK_U];
		sts.mark_r       = rd_marks[fslot_pkg::MARK_R];
		sts.addr_is_last = last_valid_q && (addr[fslot_pkg::SLOT_W-1:0] == last_q);
		sts.last_valid   = last_valid_q;
		sts.cnt_last     = (cnt_q == SIW'(SLOT_COUNT - 1));
		sts.out_free     = out_free;
	end

endmodule

`default_nettype wire

FILE: rtl/frame_slot_manager.sv
// ----------------------------------------------------------------------------
// frame_slot_manager
// Bookkeeping of frame buffer slots for a triple-buffered display path.
// ----------------------------------------------------------------------------
// The block takes one item at a time and returns exactly one result for each.
// An event or a set-last request passes from input transfer to a valid
// result through capture, dispatch, one update step and the report state.
// A get-free request walks the slots one per cycle from the round-robin
// pointer and checks at most SLOT_COUNT slots. A get-prepared request
// pops one stale queue entry per cycle. A get-renderable request pops at
// most SLOT_COUNT uploaded entries and, if none of them is renderable,
// then checks the last shown slot. This pace comes from the single
// read port on the slot mark table, stepped one address per cycle.
// The result sits in an output register, so the next input transfer can be
// taken while a result still waits for the consumer; the next result only
// waits in its report cycle if that register is still held.
// ----------------------------------------------------------------------------
`default_nettype none

module frame_slot_manager #(
	parameter int SLOT_COUNT = fslot_pkg::SLOT_COUNT_DEF,
	parameter int FIFO_DEPTH = fslot_pkg::FIFO_DEPTH_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	output logic                                   in_stall,
	input  wire logic [fslot_pkg::FUNC_W-1:0]      func,
	input  wire logic [fslot_pkg::SLOT_IN_W-1:0]   slot,
	output logic                                   out_valid,
	input  wire logic                              out_stall,
	output logic [fslot_pkg::SLOT_W-1:0]           slot_out,
	output logic                                   slot_found,
	output logic                                   queue_full,
	output logic                                   input_slot_rendering,
	output logic [fslot_pkg::SLOT_W-1:0]           last_shown,
	output logic                                   last_shown_known
);

	// Commands flow from the sequencer to the datapath, status flows back.
	fslot_pkg::fslot_cmd_t cmd;
	fslot_pkg::fslot_sts_t sts;

	// The sequencer holds in_stall high from the capture of an item until
	// its result has been loaded into the output register.
	fslot_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	// The datapath owns the marks, both queues with their pointers, the last
	// shown slot, the search pointer and the result register.
	fslot_dp #(
		.SLOT_COUNT (SLOT_COUNT),
		.FIFO_DEPTH (FIFO_DEPTH)
	) u_dp (
		.clk                  (clk),
		.arst_n               (arst_n),
		.func                 (func),
		.slot                 (slot),
		.cmd                  (cmd),
		.sts                  (sts),
		.out_valid            (out_valid),
		.out_stall            (out_stall),
		.slot_out             (slot_out),
		.slot_found           (slot_found),
		.queue_full           (queue_full),
		.input_slot_rendering (input_slot_rendering),
		.last_shown           (last_shown),
		.last_shown_known     (last_shown_known)
	);

endmodule

`default_nettype wire

FILE: rtl/fslot_chk.sv
// ----------------------------------------------------------------------------
// fslot_chk
// Port-level checks on the frame slot manager, attached by bind.
// ----------------------------------------------------------------------------
`default_nettype none

`include "frame_slot_manager_defines.svh"

module fslot_chk #(
	parameter int SLOT_COUNT = fslot_pkg::SLOT_COUNT_DEF
) (
	input wire logic                              clk,
	input wire logic                              arst_n,
	input wire logic                              in_stall,
	input wire logic                              out_valid,
	input wire logic                              out_stall,
	input wire logic [fslot_pkg::SLOT_W-1:0]      slot_out,
	input wire logic                              slot_found,
	input wire logic                              queue_full,
	input wire logic                              input_slot_rendering,
	input wire logic [fslot_pkg::SLOT_W-1:0]      last_shown,
	input wire logic                              last_shown_known
);

	// All result fields side by side, for the hold check.
	logic [2*fslot_pkg::SLOT_W+3:0] out_word;

	assign out_word = {slot_out, slot_found, queue_full, input_slot_rendering,
		last_shown, last_shown_known};

	// A stalled result stays offered and unchanged.
	`FSLOT_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_word), "result changed while stalled")

	// A granted slot always names an existing slot.
	`FSLOT_ASSERT(a_grant_range, out_valid && slot_found |-> slot_out < SLOT_COUNT, "granted slot out of range")

	// Nothing granted reads as slot zero, and no grant comes with a dropped push.
	`FSLOT_ASSERT(a_no_grant_zero, out_valid |-> (slot_found || slot_out == '0) && !(queue_full && slot_found), "result fields inconsistent")

	// Until a slot has been shown, the last shown field stays at zero.
	`FSLOT_ASSERT(a_last_unknown, out_valid && !last_shown_known |-> last_shown == '0, "last shown slot set without being known")

	// An edge inside reset leaves both handshake outputs quiet.
	`FSLOT_ASSERT_ALWAYS(a_reset_quiet, !arst_n |=> !out_valid && !in_stall, "outputs active during reset")

endmodule

bind frame_slot_manager fslot_chk #(.SLOT_COUNT(SLOT_COUNT)) u_fslot_chk (.*);

`default_nettype wire
